### rtl/core/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared constants and types for the FIFO page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NUM_W      = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 4;
  localparam int TOTAL_W    = 32;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(3);

  typedef struct packed {
    logic load;
  } fpr_cmd_t;

endpackage

`default_nettype wire

### rtl/core/fpr_ifs.sv
// ----------------------------------------------------------------------------
// fpr channel interfaces
// Reference, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [fpr_pkg::PAGE_BITS-1:0]  page;
  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface fpr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [fpr_pkg::SLOT_W-1:0]     frame_slot;
  logic                           evicted_valid;
  logic [fpr_pkg::PAGE_BITS-1:0]  evicted_page;
  logic [fpr_pkg::TOTAL_W-1:0]    fault_total;
  logic [fpr_pkg::TOTAL_W-1:0]    access_total;
  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output fault_total, output access_total,
                  input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input fault_total, input access_total,
                  output ready);
endinterface

interface fpr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpr_pkg::CFG_W-1:0]      frame_count;
  modport source (output valid, output frame_count, input ready);
  modport sink   (input valid, input frame_count, output ready);
endinterface

`default_nettype wire

### rtl/core/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Handshake controller: accepts a reference when the result register is free
// or being drained, and issues the load command to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fpr_pkg::fpr_cmd_t  cmd
);

  typedef enum logic {S_EMPTY, S_FULL} state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready  = rst_n && ((state_r == S_EMPTY) || out_ready);
  assign cmd.load  = in_valid && in_ready;
  assign out_valid = (state_r == S_FULL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EMPTY: begin
        if (cmd.load) state_nxt = S_FULL;
      end
      S_FULL: begin
        if (cmd.load)      state_nxt = S_FULL;
        else if (out_ready) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fpr_dp.sv
// ----------------------------------------------------------------------------
// fpr_dp
// Frame table, parallel page compare, FIFO victim pointer, saturating totals
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fpr_pkg::fpr_cmd_t              cmd,
  input  wire logic [fpr_pkg::PAGE_BITS-1:0]  in_page,
  input  wire logic                           cfg_we,
  input  wire logic [fpr_pkg::CFG_W-1:0]      cfg_frame_count,
  output logic                                res_hit,
  output logic [fpr_pkg::SLOT_W-1:0]          res_frame_slot,
  output logic                                res_evicted_valid,
  output logic [fpr_pkg::PAGE_BITS-1:0]       res_evicted_page,
  output logic [fpr_pkg::TOTAL_W-1:0]         res_fault_total,
  output logic [fpr_pkg::TOTAL_W-1:0]         res_access_total
);

  localparam int MF = fpr_pkg::MAX_FRAMES;
  localparam int SW = fpr_pkg::SLOT_W;
  localparam int NW = fpr_pkg::NUM_W;
  localparam int PW = fpr_pkg::PAGE_BITS;
  localparam int TW = fpr_pkg::TOTAL_W;

  logic [PW-1:0]              frame_page_r [MF];
  logic [MF-1:0]              frame_valid_r;
  logic [SW-1:0]              victim_r;
  logic [TW-1:0]              fault_r;
  logic [TW-1:0]              access_r;
  logic [fpr_pkg::CFG_W-1:0]  frame_count_r;

  logic                       hit_r;
  logic [SW-1:0]              slot_r;
  logic                       ev_valid_r;
  logic [PW-1:0]              ev_page_r;

  logic [NW-1:0]              num_c;
  logic                       found_c;
  logic [SW-1:0]              match_c;
  logic [SW-1:0]              fill_c;
  logic [SW-1:0]              victim_nxt;
  logic [TW-1:0]              fault_nxt;
  logic [TW-1:0]              access_nxt;

  always_comb begin
    if (frame_count_r == '0) begin
      num_c = NW'(1);
    end else if (32'(frame_count_r) > 32'(MF)) begin
      num_c = NW'(MF);
    end else begin
      num_c = NW'(frame_count_r);
    end
  end

  // lowest matching frame wins
  always_comb begin
    found_c = 1'b0;
    match_c = '0;
    for (int i = MF - 1; i >= 0; i--) begin
      if (frame_valid_r[i] && (frame_page_r[i] == in_page) && (32'(i) < 32'(num_c))) begin
        found_c = 1'b1;
        match_c = SW'(i);
      end
    end
  end

  always_comb begin
    fill_c     = (32'(victim_r) < 32'(num_c)) ? victim_r : '0;
    victim_nxt = (32'(fill_c) + 32'd1 >= 32'(num_c)) ? '0 : SW'(32'(fill_c) + 32'd1);
    access_nxt = (access_r == '1) ? access_r : access_r + TW'(1);
    fault_nxt  = (fault_r == '1) ? fault_r : fault_r + TW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      victim_r      <= '0;
      fault_r       <= '0;
      access_r      <= '0;
      frame_count_r <= fpr_pkg::FRAME_COUNT_RESET;
    end else begin
      if (cfg_we) frame_count_r <= cfg_frame_count;
      if (cmd.load) begin
        access_r <= access_nxt;
        if (!found_c) begin
          frame_valid_r[fill_c] <= 1'b1;
          victim_r              <= victim_nxt;
          fault_r               <= fault_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= found_c;
      if (found_c) begin
        slot_r     <= match_c;
        ev_valid_r <= 1'b0;
        ev_page_r  <= '0;
      end else begin
        frame_page_r[fill_c] <= in_page;
        slot_r               <= fill_c;
        ev_valid_r           <= frame_valid_r[fill_c];
        ev_page_r            <= frame_valid_r[fill_c] ? frame_page_r[fill_c] : '0;
      end
    end
  end

  assign res_hit           = hit_r;
  assign res_frame_slot    = slot_r;
  assign res_evicted_valid = ev_valid_r;
  assign res_evicted_page  = ev_page_r;
  assign res_fault_total   = fault_r;
  assign res_access_total  = access_r;

`ifndef NO_ASSERTIONS
  a_slot_resident: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> frame_valid_r[slot_r])
    else $error("reported frame is not resident");

  a_hit_keeps_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && found_c) |=> ($stable(victim_r) && $stable(fault_r)))
    else $error("hit changed victim pointer or fault total");

  a_idle_totals: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |=> ($stable(fault_r) && $stable(access_r)))
    else $error("totals moved without a transfer");
`endif

endmodule

`default_nettype wire

### rtl/core/fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement unit: one page reference in, one result out.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one page reference per transfer; out_ch returns one
// result per reference (hit, frame slot, evicted page, fault and access
// totals); cfg_ch writes the frame count, always ready outside reset.
// Each reference is compared against the resident frames below the frame
// count in parallel and the result is registered: out_ch.valid rises in the
// cycle after the input transfer, and one reference per cycle is sustained
// while the result register drains each cycle. The single result register
// is the only buffer; a new reference is taken in the same cycle the pending
// result transfers out.
// Reset clears the frame valid bits, victim pointer and both totals, and
// sets the frame count to 3. While out_ch is stalled the result holds and
// in_ch.ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_page_replacement (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpr_in_if.sink     in_ch,
  fpr_out_if.source  out_ch,
  fpr_cfg_if.sink    cfg_ch
);

  fpr_pkg::fpr_cmd_t cmd;

  assign cfg_ch.ready = rst_n;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fpr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_ch.page),
    .cfg_we            (cfg_ch.valid && cfg_ch.ready),
    .cfg_frame_count   (cfg_ch.frame_count),
    .res_hit           (out_ch.hit),
    .res_frame_slot    (out_ch.frame_slot),
    .res_evicted_valid (out_ch.evicted_valid),
    .res_evicted_page  (out_ch.evicted_page),
    .res_fault_total   (out_ch.fault_total),
    .res_access_total  (out_ch.access_total)
  );

endmodule

`default_nettype wire

### sim/fifo_page_replacement_test.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_test
// Self-checking bench for the FIFO page replacement unit. A queue-fed driver
// sends page references, a predictor tracks the frame table, victim pointer
// and totals, and a monitor checks every result field against it. The frame
// count is rewritten between phases, including zero and values above the
// built maximum; both sides idle at random except in the last four segments.
// ----------------------------------------------------------------------------
module fifo_page_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          hit;
    logic [fpr_pkg::SLOT_W-1:0]    frame_slot;
    logic                          evicted_valid;
    logic [fpr_pkg::PAGE_BITS-1:0] evicted_page;
    logic [fpr_pkg::TOTAL_W-1:0]   fault_total;
    logic [fpr_pkg::TOTAL_W-1:0]   access_total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpr_in_if  in_ch ();
  fpr_out_if out_ch ();
  fpr_cfg_if cfg_ch ();

  fifo_page_replacement u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted block state
  logic [fpr_pkg::PAGE_BITS-1:0] resident_page [fpr_pkg::MAX_FRAMES];
  logic                          resident_valid [fpr_pkg::MAX_FRAMES] = '{default: 1'b0};
  int                            victim_idx = 0;
  logic [fpr_pkg::TOTAL_W-1:0]   faults = '0;
  logic [fpr_pkg::TOTAL_W-1:0]   accesses = '0;
  logic [fpr_pkg::CFG_W-1:0]     frames_cfg = fpr_pkg::FRAME_COUNT_RESET;

  logic [fpr_pkg::PAGE_BITS-1:0] page_backlog [$];
  outcome_t                      expected_outcomes [$];
  int                            send_idle_pct = 24;
  int                            recv_stall_pct = 58;
  int                            error_count = 0;

  function automatic outcome_t resolve_reference(logic [fpr_pkg::PAGE_BITS-1:0] pg);
    outcome_t r;
    int       n;
    int       slot;
    bit       found;
    r = '0;
    found = 1'b0;
    slot = 0;
    if (frames_cfg == '0) n = 1;
    else if (frames_cfg > fpr_pkg::MAX_FRAMES) n = fpr_pkg::MAX_FRAMES;
    else n = int'(frames_cfg);
    for (int i = 0; i < n; i++) begin
      if (!found && resident_valid[i] && resident_page[i] == pg) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (accesses != '1) accesses = accesses + 1'b1;
    if (!found) begin
      slot = (victim_idx < n) ? victim_idx : 0;
      if (resident_valid[slot]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page = resident_page[slot];
      end
      resident_page[slot] = pg;
      resident_valid[slot] = 1'b1;
      victim_idx = (slot + 1 >= n) ? 0 : slot + 1;
      if (faults != '1) faults = faults + 1'b1;
    end
    r.hit = found;
    r.frame_slot = fpr_pkg::SLOT_W'(slot);
    r.fault_total = faults;
    r.access_total = accesses;
    return r;
  endfunction

  // driver: predict on each accepted transfer, then load the next page
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_outcomes.push_back(resolve_reference(in_ch.page));
      if (!in_ch.valid || in_ch.ready) begin
        if (page_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.page <= page_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result transfer with no reference outstanding");
          error_count++;
        end else begin
          exp_r = expected_outcomes.pop_front();
          if (out_ch.hit !== exp_r.hit) begin
            $error("hit expected %0h actual %0h", exp_r.hit, out_ch.hit);
            error_count++;
          end
          if (out_ch.frame_slot !== exp_r.frame_slot) begin
            $error("frame_slot expected %0h actual %0h", exp_r.frame_slot, out_ch.frame_slot);
            error_count++;
          end
          if (out_ch.evicted_valid !== exp_r.evicted_valid) begin
            $error("evicted_valid expected %0h actual %0h",
                   exp_r.evicted_valid, out_ch.evicted_valid);
            error_count++;
          end
          if (out_ch.evicted_page !== exp_r.evicted_page) begin
            $error("evicted_page expected %0h actual %0h",
                   exp_r.evicted_page, out_ch.evicted_page);
            error_count++;
          end
          if (out_ch.fault_total !== exp_r.fault_total) begin
            $error("fault_total expected %0h actual %0h",
                   exp_r.fault_total, out_ch.fault_total);
            error_count++;
          end
          if (out_ch.access_total !== exp_r.access_total) begin
            $error("access_total expected %0h actual %0h",
                   exp_r.access_total, out_ch.access_total);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    @(posedge clk);
    while (page_backlog.size() != 0 || in_ch.valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [fpr_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.frame_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    frames_cfg = value;
  endtask

  initial begin
    logic [fpr_pkg::CFG_W-1:0]     seg_cfg [12] = '{4'd1, 4'd8, 4'd2, 4'd5, 4'd0, 4'd15,
                                                    4'd3, 4'd7, 4'd4, 4'd9, 4'd6, 4'd8};
    logic [fpr_pkg::PAGE_BITS-1:0] pool [16];
    int                            pool_n;

    in_ch.valid = 1'b0;
    in_ch.page = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.frame_count = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // fill, hit, wrap at the reset frame count
    page_backlog.push_back(16'h0000);
    page_backlog.push_back(16'hFFFF);
    page_backlog.push_back(16'h0000);
    page_backlog.push_back(16'h1234);
    page_backlog.push_back(16'hABCD);
    page_backlog.push_back(16'hFFFF);
    // count above the maximum clamps
    write_frame_count(4'd15);
    page_backlog.push_back(16'h5555);
    page_backlog.push_back(16'hAAAA);
    page_backlog.push_back(16'h0F0F);
    page_backlog.push_back(16'hF0F0);
    // shrink: pointer past count, frames beyond count ignored
    write_frame_count(4'd2);
    page_backlog.push_back(16'h0F0F);
    page_backlog.push_back(16'h7777);
    // zero count acts as one frame
    write_frame_count(4'd0);
    page_backlog.push_back(16'h7777);
    page_backlog.push_back(16'h7777);
    // grow: duplicate residents, lowest index wins
    write_frame_count(4'd8);
    page_backlog.push_back(16'h7777);
    page_backlog.push_back(16'h0F0F);
    page_backlog.push_back(16'h8000);
    write_frame_count(4'd1);
    page_backlog.push_back(16'h8000);
    page_backlog.push_back(16'h0001);
    page_backlog.push_back(16'h0001);

    for (int seg = 0; seg < 12; seg++) begin
      wait_drained();
      if (seg < 4) begin
        send_idle_pct = 24;
        recv_stall_pct = 58;
      end else if (seg < 8) begin
        send_idle_pct = 58;
        recv_stall_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_frame_count(seg_cfg[seg]);
      pool_n = $urandom_range(1, 12);
      for (int i = 0; i < 16; i++) begin
        case ($urandom_range(19))
          0:       pool[i] = '0;
          1:       pool[i] = '1;
          default: pool[i] = fpr_pkg::PAGE_BITS'($urandom_range(16'hFFFF));
        endcase
      end
      for (int k = 0; k < 153; k++) begin
        if ($urandom_range(99) < 5)
          pool[$urandom_range(pool_n - 1)] = fpr_pkg::PAGE_BITS'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 85)
          page_backlog.push_back(pool[$urandom_range(pool_n - 1)]);
        else
          page_backlog.push_back(fpr_pkg::PAGE_BITS'($urandom_range(16'hFFFF)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d references never produced a result", expected_outcomes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $error("run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
